>>> rtl/pdm_pkg.sv
// pdm_pkg: shared types and constants of the PWM period/duty meter.
// No dependencies; imported by pdm_ctrl, pdm_datapath and the top level.
package pdm_pkg;

  localparam int unsigned CapW   = 16;
  localparam int unsigned ExtW   = 32;
  localparam int unsigned ClkW   = 27;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned FreqW  = 10;

  // iterative divider geometry: dividend holds high_time * 100
  localparam int unsigned DivDw  = 39;
  localparam int unsigned DivVw  = 32;

  localparam logic [ClkW-1:0]  ClockHzReset = 27'd8000000;
  localparam logic [DivVw-1:0] HzPerKhz     = 32'd1000;
  localparam logic [DivVw-1:0] HzPerMhz     = 32'd1000000;
  localparam logic [DutyW-1:0] DutyFull     = 7'd100;

  localparam logic [1:0] UnitHz  = 2'd0;
  localparam logic [1:0] UnitKhz = 2'd1;
  localparam logic [1:0] UnitMhz = 2'd2;

  localparam logic [0:0] ReqCapture  = 1'b0;
  localparam logic [0:0] ReqOverflow = 1'b1;

  typedef struct packed {
    logic accept;       // request taken, update edge state
    logic start_div;    // launch frequency and duty divisions
    logic start_scale;  // latch duty, unit and raw frequency
    logic finish;       // latch scaled frequency
    logic load_out;     // move result into output register
  } pdm_cmd_t;

  typedef struct packed {
    logic closing;      // request at input closes a period
    logic div_busy;     // a division is still iterating
  } pdm_sts_t;

endpackage

>>> rtl/pdm_div.sv
// pdm_div: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module pdm_div #(
  parameter int unsigned DW = 39,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [CntW-1:0] cnt_q;
  logic [VW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q;
  logic [VW:0]     shifted, diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  // borrow bit set means the trial subtract failed
  always_comb begin
    if (!diff[VW]) begin
      rem_d = diff[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = shifted[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

>>> rtl/pdm_ctrl.sv
// pdm_ctrl: sequencer of the meter; handshakes and division ordering.
// Depends on pdm_pkg for the command and status structs.
module pdm_ctrl
  import pdm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pdm_sts_t sts_i,
  output pdm_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StScale = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.closing) begin
            cmd_o.start_div = 1'b1;
            state_d         = StDiv;
          end else begin
            state_d = StWrite;
          end
        end
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          cmd_o.start_scale = 1'b1;
          state_d           = StScale;
        end
      end
      StScale: begin
        if (!sts_i.div_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = StWrite;
        end
      end
      StWrite: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/pdm_datapath.sv
// pdm_datapath: edge state, capture extension, two dividers, bar math and
// the output register. Depends on pdm_pkg and pdm_div.
module pdm_datapath
  import pdm_pkg::*;
#(
  parameter int unsigned BAR_CELLS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdm_cmd_t          cmd_i,
  output pdm_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [ClkW-1:0]   cfg_wdata_i,
  input  logic              req_type_i,
  input  logic [CapW-1:0]   capture_value_i,
  output logic              measurement_ready_o,
  output logic              arm_falling_edge_o,
  output logic [ExtW-1:0]   high_time_o,
  output logic [ExtW-1:0]   period_ticks_o,
  output logic [FreqW-1:0]  freq_scaled_o,
  output logic [1:0]        freq_unit_o,
  output logic [DutyW-1:0]  duty_percent_o,
  output logic [4:0]        bar_upper_cells_o,
  output logic [2:0]        split_glyph_o,
  output logic [4:0]        bar_lower_cells_o,
  output logic              zero_period_error_o
);

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhFall  = 2'd1;
  localparam logic [1:0] PhStop  = 2'd2;

  // bar geometry: floor(duty * BAR_CELLS / 100) by reciprocal 1310 / 2^17
  localparam int unsigned ProdW  = DutyW + $clog2(BAR_CELLS + 1);
  localparam int unsigned RecipW = ProdW + 17;
  localparam int unsigned RecipK = BAR_CELLS * 1310;

  // unit scaling by reciprocal multiply, exact over the whole frequency range
  localparam logic [20:0] RecipKhz = 21'd1073742;    // ceil(2^30 / 1000)
  localparam logic [27:0] RecipMhz = 28'd140737489;  // ceil(2^47 / 1000000)

  logic [ClkW-1:0]  clock_hz_q;
  logic [1:0]       phase_q;
  logic [CapW-1:0]  start_q, ovf_q;
  logic [ExtW-1:0]  fall_q;

  logic [ExtW-1:0]  ext_w, hi_w, per_w;
  logic             arm_w;

  logic             res_ready_q, res_arm_q;
  logic [ExtW-1:0]  hi_q, per_q;
  logic [DutyW-1:0] duty_q;
  logic [1:0]       unit_q;
  logic [FreqW-1:0] freq_q;
  logic             zero_w;

  logic             fdiv_start, ddiv_start, fdiv_busy, ddiv_busy;
  logic [DivDw-1:0] fdiv_dividend, fdiv_quo, ddiv_quo;
  logic [DivVw-1:0] fdiv_divisor;
  logic [ClkW-1:0]  f_w, f_q;
  logic [1:0]       unit_w;
  logic [DutyW-1:0] duty_w;
  logic [47:0]      khz_prod;
  logic [56:0]      mhz_prod;
  logic [FreqW-1:0] freq_w;

  assign ext_w  = {ovf_q, capture_value_i};
  assign hi_w   = fall_q - {{(ExtW-CapW){1'b0}}, start_q};
  assign per_w  = ext_w - {{(ExtW-CapW){1'b0}}, start_q};
  assign zero_w = (per_q == '0);

  assign sts_o.closing  = (req_type_i == ReqCapture) && (phase_q == PhStop);
  assign sts_o.div_busy = fdiv_busy || ddiv_busy;

  // next edge to arm follows the phase after this request
  always_comb begin
    if (req_type_i == ReqOverflow) begin
      arm_w = (phase_q == PhFall);
    end else begin
      arm_w = (phase_q != PhFall) && (phase_q != PhStop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= ClockHzReset;
    end else if (cfg_we_i) begin
      clock_hz_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      start_q <= '0;
      fall_q  <= '0;
      ovf_q   <= '0;
    end else if (cmd_i.accept) begin
      if (req_type_i == ReqOverflow) begin
        ovf_q <= ovf_q + 1'b1;
      end else if (phase_q == PhFall) begin
        fall_q  <= ext_w;
        phase_q <= PhStop;
      end else if (phase_q == PhStop) begin
        phase_q <= PhStart;
      end else begin
        ovf_q   <= '0;
        fall_q  <= '0;
        start_q <= capture_value_i;
        phase_q <= PhFall;
      end
    end
  end

  // unit picked from the raw frequency quotient
  assign f_w = fdiv_quo[ClkW-1:0];

  always_comb begin
    if ({{(DivVw-ClkW){1'b0}}, f_w} >= HzPerMhz) begin
      unit_w = UnitMhz;
    end else if ({{(DivVw-ClkW){1'b0}}, f_w} >= HzPerKhz) begin
      unit_w = UnitKhz;
    end else begin
      unit_w = UnitHz;
    end
  end

  assign fdiv_start    = cmd_i.start_div;
  assign fdiv_dividend = DivDw'(clock_hz_q);
  assign fdiv_divisor  = per_w;
  assign ddiv_start    = cmd_i.start_div;

  pdm_div #(
    .DW (DivDw),
    .VW (DivVw)
  ) u_freq_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fdiv_start),
    .dividend_i (fdiv_dividend),
    .divisor_i  (fdiv_divisor),
    .busy_o     (fdiv_busy),
    .quotient_o (fdiv_quo)
  );

  pdm_div #(
    .DW (DivDw),
    .VW (DivVw)
  ) u_duty_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ddiv_start),
    .dividend_i (DivDw'(hi_w) * DivDw'(DutyFull)),
    .divisor_i  (per_w),
    .busy_o     (ddiv_busy),
    .quotient_o (ddiv_quo)
  );

  // duty saturates at 100 when high time exceeds the period
  assign duty_w = (ddiv_quo > DivDw'(DutyFull)) ? DutyFull : ddiv_quo[DutyW-1:0];

  // scaled frequency from the latched raw quotient and unit
  assign khz_prod = 48'(f_q) * 48'(RecipKhz);
  assign mhz_prod = 57'(f_q) * 57'(RecipMhz);

  always_comb begin
    case (unit_q)
      UnitMhz: freq_w = mhz_prod[56:47];
      UnitKhz: freq_w = khz_prod[39:30];
      default: freq_w = f_q[FreqW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready_q <= 1'b0;
      res_arm_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      res_ready_q <= sts_o.closing;
      res_arm_q   <= arm_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hi_q   <= hi_w;
      per_q  <= per_w;
      duty_q <= '0;
      unit_q <= UnitHz;
      freq_q <= '0;
    end
    if (cmd_i.start_scale) begin
      f_q <= f_w;
    end
    if (cmd_i.start_scale && !zero_w) begin
      duty_q <= duty_w;
      unit_q <= unit_w;
    end
    if (cmd_i.finish && !zero_w) begin
      freq_q <= freq_w;
    end
  end

  // bar cells and split glyph from the latched duty
  logic [RecipW-1:0] est_prod;
  logic [ProdW-1:0]  prod_w, est_w, rem_w, upper_w, lower_w;
  logic [14:0]       tens_prod;
  logic [3:0]        tens_w;
  logic [DutyW-1:0]  ones_w;
  logic [2:0]        glyph_w;

  assign est_prod = RecipW'(duty_q) * RecipW'(RecipK);
  assign est_w    = est_prod[RecipW-1:17];
  assign prod_w   = ProdW'(duty_q) * ProdW'(BAR_CELLS);
  assign rem_w    = prod_w - est_w * ProdW'(100);
  assign upper_w  = (rem_w >= ProdW'(100)) ? est_w + 1'b1 : est_w;
  assign lower_w  = ProdW'(BAR_CELLS) - upper_w;

  // duty / 10 as (duty * 205) >> 11, exact below 1029
  assign tens_prod = 15'(duty_q) * 15'd205;
  assign tens_w    = tens_prod[14:11];
  assign ones_w    = duty_q - DutyW'(tens_w) * DutyW'(10);
  assign glyph_w   = ones_w[3:1] + 3'd2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      measurement_ready_o <= res_ready_q;
      arm_falling_edge_o  <= res_arm_q;
      high_time_o         <= res_ready_q ? hi_q : '0;
      period_ticks_o      <= res_ready_q ? per_q : '0;
      freq_scaled_o       <= res_ready_q ? freq_q : '0;
      freq_unit_o         <= res_ready_q ? unit_q : UnitHz;
      duty_percent_o      <= res_ready_q ? duty_q : '0;
      bar_upper_cells_o   <= res_ready_q ? upper_w[4:0] : '0;
      split_glyph_o       <= res_ready_q ? glyph_w : '0;
      bar_lower_cells_o   <= res_ready_q ? lower_w[4:0] : '0;
      zero_period_error_o <= res_ready_q && zero_w;
    end
  end

endmodule

>>> rtl/pwm_period_duty_meter.sv
// pwm_period_duty_meter: top level, joins the sequencer and the datapath.
// Depends on pdm_pkg, pdm_ctrl, pdm_datapath (which holds pdm_div).
//
// Usage: each input request is either a timer overflow tick (req_type 1) or
// an input-capture edge (req_type 0) with its 16-bit timer value. Edges walk
// rising, falling, rising; the second rising edge closes a period. Every
// request yields exactly one result on the output valid/ready channel.
// Sequencing: a tick or a non-closing edge goes straight to the output
// register write, which waits only for a free output slot. A closing
// edge runs two restoring divisions in parallel (frequency and duty),
// then latches duty, unit and raw frequency, then scales the frequency by
// reciprocal multiply, then loads the output register. The block takes one
// request at a time: the next request is taken only after the result is
// loaded.
// The output register holds a finished result while the receiver stalls; the
// next request is still taken and computed, its result waits until the slot
// frees, and the input stalls meanwhile.
// The clock_hz register is written through cfg_we_i/cfg_wdata_i with no
// wait; write it only while the block is idle.
// Reset: phase back to awaiting the first rising edge, captures and overflow
// count cleared, clock_hz to 8 MHz, no result pending.
module pwm_period_duty_meter
  import pdm_pkg::*;
#(
  parameter int unsigned BAR_CELLS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ClkW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [CapW-1:0]  capture_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             measurement_ready_o,
  output logic             arm_falling_edge_o,
  output logic [ExtW-1:0]  high_time_o,
  output logic [ExtW-1:0]  period_ticks_o,
  output logic [FreqW-1:0] freq_scaled_o,
  output logic [1:0]       freq_unit_o,
  output logic [DutyW-1:0] duty_percent_o,
  output logic [4:0]       bar_upper_cells_o,
  output logic [2:0]       split_glyph_o,
  output logic [4:0]       bar_lower_cells_o,
  output logic             zero_period_error_o
);

  pdm_cmd_t cmd;
  pdm_sts_t sts;

  pdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdm_datapath #(
    .BAR_CELLS (BAR_CELLS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .req_type_i          (req_type_i),
    .capture_value_i     (capture_value_i),
    .measurement_ready_o (measurement_ready_o),
    .arm_falling_edge_o  (arm_falling_edge_o),
    .high_time_o         (high_time_o),
    .period_ticks_o      (period_ticks_o),
    .freq_scaled_o       (freq_scaled_o),
    .freq_unit_o         (freq_unit_o),
    .duty_percent_o      (duty_percent_o),
    .bar_upper_cells_o   (bar_upper_cells_o),
    .split_glyph_o       (split_glyph_o),
    .bar_lower_cells_o   (bar_lower_cells_o),
    .zero_period_error_o (zero_period_error_o)
  );

endmodule

>>> verif/tb_pwm_period_duty_meter.sv
// tb_pwm_period_duty_meter: self-checking testbench of the PWM period/duty meter.
// Needs pdm_pkg and the RTL of pwm_period_duty_meter. Predicts every result in a
// scoreboard class, drives random handshake gaps, and sweeps the clock_hz register.
module tb_pwm_period_duty_meter;
  import pdm_pkg::*;

  localparam int unsigned BarCells     = 16;
  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned MaxGap       = 13;
  localparam int unsigned SettleCycles = 120;  // longer than a closing-edge computation
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SegItems     = 260;
  localparam int unsigned NumSegments  = 6;
  localparam int unsigned MaxReports   = 40;
  localparam longint unsigned LimitCycles = 3000000;

  typedef enum logic [1:0] {
    AwaitRise  = 2'd0,
    AwaitFall  = 2'd1,
    AwaitClose = 2'd2
  } edge_phase_e;

  typedef struct packed {
    logic             meas;
    logic             arm_fall;
    logic [ExtW-1:0]  high;
    logic [ExtW-1:0]  period;
    logic [FreqW-1:0] freq;
    logic [1:0]       unit;
    logic [DutyW-1:0] duty;
    logic [4:0]       upper;
    logic [2:0]       split;
    logic [4:0]       lower;
    logic             zero;
  } meter_reading_t;

  class meter_scoreboard;
    edge_phase_e     phase;
    logic [CapW-1:0] start_cap;
    logic [ExtW-1:0] fall_ext;
    logic [CapW-1:0] overflows;
    logic [ClkW-1:0] clock_hz;
    meter_reading_t  pending_readings[$];
    int unsigned     errors, reports, requests, checked;
    int unsigned     periods, zero_periods, saturated;
    int unsigned     unit_hits[3];

    function new();
      clock_hz  = ClockHzReset;
      phase     = AwaitRise;
      start_cap = '0;
      fall_ext  = '0;
      overflows = '0;
      errors = 0; reports = 0; requests = 0; checked = 0;
      periods = 0; zero_periods = 0; saturated = 0;
      unit_hits = '{0, 0, 0};
    endfunction

    function void predict_reading(logic req, logic [CapW-1:0] cap);
      meter_reading_t r;
      logic [ExtW-1:0] close_ext;
      logic [ExtW-1:0] f;
      logic [63:0]     duty_q;
      r = '0;
      requests++;
      if (req == ReqOverflow) begin
        overflows = overflows + 1'b1;
      end else if (phase == AwaitFall) begin
        fall_ext = {overflows, cap};
        phase    = AwaitClose;
      end else if (phase == AwaitClose) begin
        close_ext = {overflows, cap};
        r.meas    = 1'b1;
        r.high    = fall_ext - {{(ExtW-CapW){1'b0}}, start_cap};
        r.period  = close_ext - {{(ExtW-CapW){1'b0}}, start_cap};
        r.split   = 3'd2;
        r.lower   = 5'(BarCells);
        if (r.period == '0) begin
          r.zero = 1'b1;
          zero_periods++;
        end else begin
          f = {{(ExtW-ClkW){1'b0}}, clock_hz} / r.period;
          if (f >= HzPerMhz) begin
            r.freq = FreqW'(f / HzPerMhz);
            r.unit = UnitMhz;
          end else if (f >= HzPerKhz) begin
            r.freq = FreqW'(f / HzPerKhz);
            r.unit = UnitKhz;
          end else begin
            r.freq = FreqW'(f);
            r.unit = UnitHz;
          end
          duty_q = ({32'd0, r.high} * 64'd100) / {32'd0, r.period};
          if (duty_q > 64'(DutyFull)) begin
            duty_q = 64'(DutyFull);
            saturated++;
          end
          r.duty  = duty_q[DutyW-1:0];
          r.upper = 5'((r.duty * BarCells) / 100);
          r.split = 3'((r.duty % 10) / 2 + 2);
          r.lower = 5'(BarCells - r.upper);
          unit_hits[r.unit]++;
        end
        periods++;
        phase = AwaitRise;
      end else begin
        // first rising edge, also taken for the unused phase code
        overflows = '0;
        fall_ext  = '0;
        start_cap = cap;
        phase     = AwaitFall;
      end
      r.arm_fall = (phase == AwaitFall);
      pending_readings.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (reports < MaxReports)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        reports++;
      end
    endfunction

    function void check_result(meter_reading_t got);
      meter_reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        if (reports < MaxReports)
          $display("%0t: result with no request pending, expected none, actual %p",
                   $time, got);
        reports++;
        return;
      end
      want = pending_readings.pop_front();
      checked++;
      compare("measurement_ready", 64'(want.meas), 64'(got.meas));
      compare("arm_falling_edge", 64'(want.arm_fall), 64'(got.arm_fall));
      compare("high_time", 64'(want.high), 64'(got.high));
      compare("period_ticks", 64'(want.period), 64'(got.period));
      compare("freq_scaled", 64'(want.freq), 64'(got.freq));
      compare("freq_unit", 64'(want.unit), 64'(got.unit));
      compare("duty_percent", 64'(want.duty), 64'(got.duty));
      compare("bar_upper_cells", 64'(want.upper), 64'(got.upper));
      compare("split_glyph", 64'(want.split), 64'(got.split));
      compare("bar_lower_cells", 64'(want.lower), 64'(got.lower));
      compare("zero_period_error", 64'(want.zero), 64'(got.zero));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [ClkW-1:0]  cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             req_type;
  logic [CapW-1:0]  capture_value;
  logic             out_valid;
  logic             out_ready;
  logic             measurement_ready;
  logic             arm_falling_edge;
  logic [ExtW-1:0]  high_time;
  logic [ExtW-1:0]  period_ticks;
  logic [FreqW-1:0] freq_scaled;
  logic [1:0]       freq_unit;
  logic [DutyW-1:0] duty_percent;
  logic [4:0]       bar_upper_cells;
  logic [2:0]       split_glyph;
  logic [4:0]       bar_lower_cells;
  logic             zero_period_error;

  meter_scoreboard meter_sb;
  bit              no_idle;
  int unsigned     hold_request;
  int unsigned     clock_settings;

  pwm_period_duty_meter #(
    .BAR_CELLS(BarCells)
  ) DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .capture_value_i    (capture_value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .measurement_ready_o(measurement_ready),
    .arm_falling_edge_o (arm_falling_edge),
    .high_time_o        (high_time),
    .period_ticks_o     (period_ticks),
    .freq_scaled_o      (freq_scaled),
    .freq_unit_o        (freq_unit),
    .duty_percent_o     (duty_percent),
    .bar_upper_cells_o  (bar_upper_cells),
    .split_glyph_o      (split_glyph),
    .bar_lower_cells_o  (bar_lower_cells),
    .zero_period_error_o(zero_period_error)
  );

  always begin
    #(ClkPeriod / 2) clk = 1'b1;
    #(ClkPeriod / 2) clk = 1'b0;
  end

  // Every task starts and ends at a falling edge.
  task automatic send_request(logic req, logic [CapW-1:0] cap);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    capture_value <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    meter_sb.predict_reading(req, cap);
    @(negedge clk);
  endtask

  task automatic send_ticks(int unsigned count);
    repeat (count) send_request(ReqOverflow, CapW'($urandom));
  endtask

  // rising, falling, closing rising edge with overflow ticks in between
  task automatic measure_period(logic [CapW-1:0] rise_cap, logic [CapW-1:0] fall_cap,
                                logic [CapW-1:0] close_cap, int unsigned ticks_high,
                                int unsigned ticks_low);
    send_request(ReqCapture, rise_cap);
    send_ticks(ticks_high);
    send_request(ReqCapture, fall_cap);
    send_ticks(ticks_low);
    send_request(ReqCapture, close_cap);
  endtask

  task automatic wait_idle(int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (meter_sb.pending_readings.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_clock(logic [ClkW-1:0] hz);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    meter_sb.clock_hz = hz;
    clock_settings++;
  endtask

  function automatic logic [CapW-1:0] near_capture(logic [CapW-1:0] base);
    case ($urandom_range(0, 2))
      0:       return CapW'(base + $urandom_range(0, 20));
      1:       return CapW'(base + $urandom_range(0, 4000));
      default: return CapW'($urandom);
    endcase
  endfunction

  function automatic int unsigned tick_count();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 0;
    if (pick < 9) return $urandom_range(1, 2);
    return $urandom_range(3, 20);
  endfunction

  // mostly complete periods with random captures, some stray requests
  task automatic run_random(int unsigned n_items);
    int unsigned     done;
    int unsigned     ticks_high, ticks_low;
    logic [CapW-1:0] rise_cap, fall_cap, close_cap;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_request(1'($urandom_range(0, 1)), CapW'($urandom));
        done++;
      end else begin
        rise_cap   = CapW'($urandom);
        fall_cap   = near_capture(rise_cap);
        close_cap  = near_capture(fall_cap);
        ticks_high = tick_count();
        ticks_low  = tick_count();
        if ($urandom_range(0, 29) == 0) begin
          close_cap  = rise_cap;
          ticks_high = 0;
          ticks_low  = 0;
        end
        measure_period(rise_cap, fall_cap, close_cap, ticks_high, ticks_low);
        done += 3 + ticks_high + ticks_low;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned    stall;
    meter_reading_t got;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.meas     = measurement_ready;
      got.arm_fall = arm_falling_edge;
      got.high     = high_time;
      got.period   = period_ticks;
      got.freq     = freq_scaled;
      got.unit     = freq_unit;
      got.duty     = duty_percent;
      got.upper    = bar_upper_cells;
      got.split    = split_glyph;
      got.lower    = bar_lower_cells;
      got.zero     = zero_period_error;
      meter_sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #(LimitCycles * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned     seg;
    logic [ClkW-1:0] hz;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    req_type      = ReqCapture;
    capture_value = '0;
    no_idle       = 1'b0;
    hold_request  = 0;
    clock_settings = 0;
    meter_sb      = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed cases at the reset clock of 8 MHz
    send_request(ReqOverflow, 16'hFFFF);
    measure_period(16'h0000, 16'hFFFF, 16'h0000, 0, 0);  // zero period, fall past close
    measure_period(16'd100, 16'd50, 16'd200, 1, 1);      // captures extended by ticks
    measure_period(16'd10, 16'd11, 16'd12, 0, 0);        // MHz range
    measure_period(16'd0, 16'd500, 16'd1000, 0, 0);      // kHz range
    measure_period(16'd5, 16'd105, 16'd105, 0, 0);       // full duty
    measure_period(16'd7, 16'd7, 16'd1007, 0, 0);        // zero duty
    measure_period(16'hFFFF, 16'h0000, 16'h0001, 0, 0);  // close below start, wraps

    wait_idle(SettleCycles);
    write_clock('0);                                     // zero clock gives 0 Hz
    measure_period(16'd0, 16'd1, 16'd2, 0, 0);
    wait_idle(SettleCycles);
    write_clock('1);
    measure_period(16'h8000, 16'h8000, 16'h8001, 0, 0);
    wait_idle(SettleCycles);
    write_clock(27'd100000000);
    measure_period(16'd1, 16'd2, 16'd3, 0, 0);

    // overflow count past 8 bits extends the fall and close captures
    wait_idle(SettleCycles);
    write_clock(27'd1000);
    no_idle = 1'b1;
    measure_period(16'd3, 16'h1234, 16'h0010, 300, 2);
    no_idle = 1'b0;

    for (seg = 0; seg < NumSegments; seg++) begin
      wait_idle(SettleCycles);
      case (seg)
        0:       hz = ClockHzReset;
        1:       hz = 27'd100000000;
        2:       hz = 27'd1;
        3:       hz = ClkW'($urandom_range(1, 100000000));
        4:       hz = '1;
        default: hz = ClkW'($urandom);
      endcase
      write_clock(hz);
      no_idle = (seg == 3);
      if (seg == 1) hold_request = LongHold;  // output backs up, input stalls
      if (seg == 2) begin
        run_random(SegItems / 2);
        wait_idle(0);
        run_random(SegItems - SegItems / 2);
      end else begin
        run_random(SegItems);
      end
    end
    no_idle = 1'b0;

    wait_idle(SettleCycles);
    $display("Covered %0d requests over %0d clock settings, %0d results checked, %0d errors",
             meter_sb.requests, clock_settings, meter_sb.checked, meter_sb.errors);
    $display("Periods %0d: zero %0d, saturated duty %0d, Hz/kHz/MHz %0d/%0d/%0d",
             meter_sb.periods, meter_sb.zero_periods, meter_sb.saturated,
             meter_sb.unit_hits[0], meter_sb.unit_hits[1], meter_sb.unit_hits[2]);
    if (meter_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
